// File: rtl/msbs_pkg.sv
// shared constants, codes and queue entry type for the multi-signature byte scanner
// no dependencies; imported by every module of the scanner
`default_nettype none

package msbs_pkg;

    localparam int NUM_SLOTS       = 8;
    localparam int MAX_PATTERN_LEN = 32;
    localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;

    localparam int BYTE_W = 8;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
    localparam int OFFS_W = $clog2(MAX_PATTERN_LEN);
    localparam int POS_W  = 14;

    localparam logic [POS_W-1:0] SCAN_LIMIT_RESET = POS_W'(10000);
    localparam logic [POS_W-1:0] MAX_SCAN_POS     = POS_W'(16383);

    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 2 ** QPTR_W;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SCAN = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]                    pos;
        logic [NUM_SLOTS-1:0]                mask;
        logic [NUM_SLOTS-1:0][LEN_W-1:0]     lens;
    } scan_entry_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/msbs_front.sv
// front end: accepts items, holds signatures, window, count and scan limit
// compares every slot against the window in parallel; uses msbs_pkg
`default_nettype none

module msbs_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msbs_pkg::POS_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [msbs_pkg::SLOT_W-1:0]  slot,
    input  logic [msbs_pkg::LEN_W-1:0]   pattern_length,
    input  logic [msbs_pkg::OFFS_W-1:0]  byte_offset,
    input  logic [msbs_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         buffer_start,
    input  msbs_pkg::queue_status_t      q_status,
    output logic                         push_valid,
    output msbs_pkg::scan_entry_t        push_entry
);
    import msbs_pkg::*;

    logic [NUM_SLOTS-1:0][MAX_PATTERN_LEN-1:0][BYTE_W-1:0] pat_reg;
    logic [NUM_SLOTS-1:0][LEN_W-1:0]                       len_reg;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0]                     win_reg;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0]                     win_next;
    logic [POS_W-1:0]                                      seen_reg;
    logic [POS_W-1:0]                                      seen_next;
    logic [POS_W-1:0]                                      limit_reg;

    logic                                                  accept;
    logic                                                  load_acc;
    logic                                                  scan_acc;
    logic                                                  slot_ok;
    logic                                                  offs_ok;
    logic [LEN_W-1:0]                                      len_sat;
    logic [POS_W-1:0]                                      pos_eff;
    logic [POS_W:0]                                        pos_plus;
    logic                                                  in_range;
    logic [HIST_DEPTH-1:0][BYTE_W-1:0]                     win_eff;
    logic [MAX_PATTERN_LEN-1:0][BYTE_W-1:0]                cr_vec;
    logic [NUM_SLOTS-1:0][LEN_W-1:0]                       shift_bytes;
    logic [NUM_SLOTS-1:0][MAX_PATTERN_LEN-1:0][BYTE_W-1:0] aligned;
    logic [NUM_SLOTS-1:0][MAX_PATTERN_LEN-1:0]             eq;
    logic [NUM_SLOTS-1:0]                                  mask;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign accept    = in_valid && !in_stall;
    assign load_acc  = accept && (kind == KIND_LOAD) && slot_ok;
    assign scan_acc  = accept && (kind == KIND_SCAN);
    assign slot_ok   = int'(slot) < NUM_SLOTS;
    assign offs_ok   = int'(byte_offset) < MAX_PATTERN_LEN;
    assign len_sat   = (pattern_length > LEN_W'(MAX_PATTERN_LEN)) ?
                       LEN_W'(MAX_PATTERN_LEN) : pattern_length;

    always_comb
    begin
        pos_eff  = buffer_start ? '0 : seen_reg;
        win_eff  = buffer_start ? '0 : win_reg;
        pos_plus = {1'b0, pos_eff} + 1'b1;
        in_range = (pos_eff < limit_reg) && (pos_eff != MAX_SCAN_POS);

        // reversed window: newest byte at the top
        cr_vec[MAX_PATTERN_LEN-1] = data_byte;
        for (int m = 0; m < HIST_DEPTH; m++)
        begin
            cr_vec[m] = win_eff[HIST_DEPTH-1-m];
        end

        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            shift_bytes[s] = LEN_W'(MAX_PATTERN_LEN) - len_reg[s];
            aligned[s]     = cr_vec >> {shift_bytes[s], 3'b000};
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                eq[s][j] = (pat_reg[s][j] == aligned[s][j]) || (LEN_W'(j) >= len_reg[s]);
            end
            mask[s] = (&eq[s]) && (len_reg[s] != '0) &&
                      ((POS_W+1)'(len_reg[s]) <= pos_plus);
        end

        if (in_range)
        begin
            seen_next = pos_plus[POS_W-1:0];
            win_next  = {win_eff[HIST_DEPTH-2:0], data_byte};
        end
        else
        begin
            seen_next = pos_eff;
            win_next  = win_eff;
        end
    end

    assign push_valid      = scan_acc && in_range && (|mask);
    assign push_entry.pos  = pos_eff;
    assign push_entry.mask = mask;
    assign push_entry.lens = len_reg;

    always_ff @(posedge clk)
    begin
        if (load_acc && offs_ok)
        begin
            pat_reg[slot][byte_offset] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            win_reg   <= '0;
            seen_reg  <= '0;
            limit_reg <= SCAN_LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (load_acc)
            begin
                len_reg[slot] <= len_sat;
            end
            if (scan_acc)
            begin
                seen_reg <= seen_next;
                win_reg  <= win_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/msbs_queue.sv
// short queue of scan entries between the front end and the result sequencer
// uses scan_entry_t and queue_status_t from msbs_pkg
`default_nettype none

module msbs_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push_valid,
    input  msbs_pkg::scan_entry_t    push_entry,
    input  logic                     pop,
    output msbs_pkg::queue_status_t  q_status,
    output msbs_pkg::scan_entry_t    head_entry
);
    import msbs_pkg::*;

    scan_entry_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W:0]      count_reg;
    logic [QPTR_W:0]      count_next;

    assign q_status.full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.head_valid = (count_reg != '0);
    assign head_entry          = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/msbs_back.sv
// result sequencer: walks the match mask of the head entry, one result per cycle while out_stall
// is low, lowest slot first, into the output register; uses msbs_pkg
`default_nettype none

module msbs_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msbs_pkg::queue_status_t      q_status,
    input  msbs_pkg::scan_entry_t        head_entry,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [msbs_pkg::POS_W-1:0]   match_start,
    output logic [msbs_pkg::SLOT_W-1:0]  match_slot,
    output logic [msbs_pkg::LEN_W-1:0]   match_length,
    output logic                         last
);
    import msbs_pkg::*;

    logic [NUM_SLOTS-1:0]  done_reg;
    logic [NUM_SLOTS-1:0]  done_next;
    logic [NUM_SLOTS-1:0]  rem;
    logic [NUM_SLOTS-1:0]  low_bit;
    logic [SLOT_W-1:0]     sel;
    logic                  is_last;
    logic                  advance;
    logic                  load;
    logic [LEN_W-1:0]      sel_len;
    logic [POS_W:0]        start_wide;

    logic                  out_valid_reg;
    logic [POS_W-1:0]      start_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [LEN_W-1:0]      len_reg;
    logic                  last_reg;

    assign rem     = head_entry.mask & ~done_reg;
    assign low_bit = rem & (~rem + 1'b1);
    assign is_last = (rem & ~low_bit) == '0;
    assign advance = !out_valid_reg || !out_stall;
    assign load    = q_status.head_valid && advance;
    assign pop     = load && is_last;

    always_comb
    begin
        sel = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (rem[s])
            begin
                sel = SLOT_W'(s);
            end
        end
        sel_len    = head_entry.lens[sel];
        start_wide = {1'b0, head_entry.pos} + 1'b1 - (POS_W+1)'(sel_len);

        done_next = done_reg;
        if (load)
        begin
            done_next = is_last ? '0 : (done_reg | low_bit);
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_start  = start_reg;
    assign match_slot   = slot_reg;
    assign match_length = len_reg;
    assign last         = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg <= start_wide[POS_W-1:0];
            slot_reg  <= sel;
            len_reg   <= sel_len;
            last_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (advance)
            begin
                out_valid_reg <= q_status.head_valid;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/multi_signature_byte_scanner_core.sv
// top level of the multi-signature byte scanner
// instantiates msbs_front, msbs_queue and msbs_back; uses msbs_pkg
//
//   channel   direction   handshake              payload
//   cfg       in          cfg_valid/cfg_ready    cfg_data (scan_limit)
//   in        in          in_valid/in_stall      kind slot pattern_length byte_offset
//                                                data_byte buffer_start
//   out       out         out_valid/out_stall    match_start match_slot match_length last
//
// input takes one item per cycle while in_stall is low; all slot compares run in parallel
// in the front end; output gives one result per cycle while out_stall is low, so a byte
// with n matches gives n results in turn; a four-entry queue absorbs bursts; in_stall
// rises only while the queue is full; with an empty queue the first result of a byte is
// pushed into the queue as the byte is taken, then registered into the output register
// reset: all slots disabled, window and count zero, scan_limit 10000; no clearing pass
`default_nettype none

module multi_signature_byte_scanner_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [msbs_pkg::POS_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         kind,
    input  logic [msbs_pkg::SLOT_W-1:0]  slot,
    input  logic [msbs_pkg::LEN_W-1:0]   pattern_length,
    input  logic [msbs_pkg::OFFS_W-1:0]  byte_offset,
    input  logic [msbs_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         buffer_start,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [msbs_pkg::POS_W-1:0]   match_start,
    output logic [msbs_pkg::SLOT_W-1:0]  match_slot,
    output logic [msbs_pkg::LEN_W-1:0]   match_length,
    output logic                         last
);
    import msbs_pkg::*;

    queue_status_t  q_status;
    logic           push_valid;
    scan_entry_t    push_entry;
    logic           pop;
    scan_entry_t    head_entry;

    msbs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .slot           (slot),
        .pattern_length (pattern_length),
        .byte_offset    (byte_offset),
        .data_byte      (data_byte),
        .buffer_start   (buffer_start),
        .q_status       (q_status),
        .push_valid     (push_valid),
        .push_entry     (push_entry)
    );

    msbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .q_status   (q_status),
        .head_entry (head_entry)
    );

    msbs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_start  (match_start),
        .match_slot   (match_slot),
        .match_length (match_length),
        .last         (last)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> !q_status.full)
        else $error("push into full queue");

    // a load item never produces queue traffic
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind == KIND_LOAD) |-> !push_valid)
        else $error("load item pushed a scan entry");

    // retiring a queue entry always shows its final result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && last))
        else $error("entry retired without final result");

    // a pushed entry always carries at least one match
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_entry.mask != '0))
        else $error("empty match mask pushed");

endmodule

`default_nettype wire

// File: bench/multi_signature_byte_scanner_core_test.sv
// self-checking testbench for multi_signature_byte_scanner_core: random signature loads,
// scanned buffers with embedded signatures, scan_limit changes and random idling on both sides
// depends on msbs_pkg and the scanner rtl only
`default_nettype none

module multi_signature_byte_scanner_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msbs_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  plen;
        logic [OFFS_W-1:0] offs;
        logic [BYTE_W-1:0] data;
        logic              bstart;
    } byte_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  start;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic              last;
    } match_t;

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [POS_W-1:0]  cfg_data       = '0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              kind           = KIND_LOAD;
    logic [SLOT_W-1:0] slot           = '0;
    logic [LEN_W-1:0]  pattern_length = '0;
    logic [OFFS_W-1:0] byte_offset    = '0;
    logic [BYTE_W-1:0] data_byte      = '0;
    logic              buffer_start   = 1'b0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [POS_W-1:0]  match_start;
    logic [SLOT_W-1:0] match_slot;
    logic [LEN_W-1:0]  match_length;
    logic              last;

    multi_signature_byte_scanner_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .slot           (slot),
        .pattern_length (pattern_length),
        .byte_offset    (byte_offset),
        .data_byte      (data_byte),
        .buffer_start   (buffer_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .match_start    (match_start),
        .match_slot     (match_slot),
        .match_length   (match_length),
        .last           (last)
    );

    byte_item_t item_queue[$];
    match_t     pending_matches[$];

    // scanner state as predicted
    logic [BYTE_W-1:0] sig_mem [NUM_SLOTS][MAX_PATTERN_LEN];
    logic [LEN_W-1:0]  sig_len [NUM_SLOTS];
    logic [BYTE_W-1:0] window [HIST_DEPTH];
    logic [POS_W-1:0]  buf_pos         = '0;
    logic [POS_W-1:0]  limit_model     = SCAN_LIMIT_RESET;

    // generator shadow of what has been queued
    logic [BYTE_W-1:0]          gen_sig [NUM_SLOTS][MAX_PATTERN_LEN];
    int                         gen_len [NUM_SLOTS];
    logic [MAX_PATTERN_LEN-1:0] gen_filled [NUM_SLOTS];
    int                         gen_count = 0;

    bit         idle_in      = 1'b0;
    bit         idle_out     = 1'b0;
    int         in_gap       = 0;
    int         out_hold     = 0;
    byte_item_t cur_item;
    match_t     want;
    int         errors       = 0;
    int         loads_done   = 0;
    int         scans_done   = 0;
    int         matches_seen = 0;
    int         most_hits    = 0;
    int         limits_used  = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("multi_signature_byte_scanner_core_test: FAIL");
        $finish;
    end

    function automatic int draw_wait(bit on);
        if (!on || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic void predict_item(byte_item_t it);
        match_t hits[$];
        match_t m;
        int     pos;
        int     len;
        bit     hit;
        if (it.kind == KIND_LOAD)
        begin
            sig_mem[it.slot][it.offs] = it.data;
            sig_len[it.slot] = (it.plen > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : it.plen;
            return;
        end
        if (it.bstart)
        begin
            buf_pos = '0;
            foreach (window[i])
                window[i] = '0;
        end
        pos = buf_pos;
        if (pos >= limit_model || pos >= MAX_SCAN_POS)
            return;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            len = sig_len[s];
            if (len == 0 || len > pos + 1)
                continue;
            hit = (sig_mem[s][len-1] == it.data);
            for (int i = 0; i + 1 < len; i++)
                if (sig_mem[s][i] != window[len-2-i])
                    hit = 1'b0;
            if (hit)
            begin
                m.start = POS_W'(pos + 1 - len);
                m.slot  = SLOT_W'(s);
                m.len   = LEN_W'(len);
                m.last  = 1'b0;
                hits.push_back(m);
            end
        end
        for (int i = 0; i < hits.size(); i++)
        begin
            m = hits[i];
            m.last = (i == hits.size() - 1);
            pending_matches.push_back(m);
        end
        if (hits.size() > most_hits)
            most_hits = hits.size();
        for (int i = HIST_DEPTH - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = it.data;
        buf_pos = POS_W'(pos + 1);
    endfunction

    function automatic void push_load(int s, int o, int d, int pl);
        byte_item_t it;
        it.kind   = KIND_LOAD;
        it.slot   = SLOT_W'(s);
        it.offs   = OFFS_W'(o);
        it.data   = BYTE_W'(d);
        it.plen   = LEN_W'(pl);
        it.bstart = 1'($urandom_range(0, 1));
        item_queue.push_back(it);
        gen_sig[s][o]    = BYTE_W'(d);
        gen_filled[s][o] = 1'b1;
        gen_len[s]       = (pl > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : pl;
        gen_count++;
    endfunction

    // any length that enables a slot must find every byte below it written
    function automatic void queue_load(int s, int o, int d, int pl);
        int eff;
        eff = (pl > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : pl;
        for (int k = 0; k < eff; k++)
            if (!gen_filled[s][k] && k != o)
                push_load(s, k, $urandom_range(0, 255), pl);
        push_load(s, o, d, pl);
    endfunction

    function automatic void push_scan(int d, bit bs);
        byte_item_t it;
        it.kind   = KIND_SCAN;
        it.slot   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        it.offs   = OFFS_W'($urandom_range(0, MAX_PATTERN_LEN - 1));
        it.plen   = LEN_W'($urandom_range(0, 63));
        it.data   = BYTE_W'(d);
        it.bstart = bs;
        item_queue.push_back(it);
        gen_count++;
    endfunction

    function automatic int pick_byte(bit narrow);
        if (narrow)
            return 8'h41 + $urandom_range(0, 3);
        return $urandom_range(0, 255);
    endfunction

    function automatic void load_signature(int s, int n, bit narrow);
        int eff;
        eff = (n > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : n;
        for (int o = 0; o < eff; o++)
            push_load(s, o, pick_byte(narrow), (o == eff - 1) ? n : 0);
    endfunction

    function automatic void scan_buffer();
        int n;
        int k;
        int s;
        bit narrow;
        bit bs;
        n      = $urandom_range(1, 40);
        narrow = ($urandom_range(0, 9) < 7);
        bs     = ($urandom_range(0, 4) != 0);
        k      = 0;
        while (k < n)
        begin
            s = $urandom_range(0, NUM_SLOTS - 1);
            if ($urandom_range(0, 2) == 0 && gen_len[s] != 0)
            begin
                for (int i = 0; i < gen_len[s]; i++)
                begin
                    push_scan(gen_sig[s][i], bs);
                    bs = 1'b0;
                end
                k += gen_len[s];
            end
            else
            begin
                push_scan(pick_byte(narrow), bs);
                bs = 1'b0;
                k++;
            end
        end
    endfunction

    function automatic int draw_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 6);
        if (r < 9)
            return $urandom_range(7, MAX_PATTERN_LEN);
        return $urandom_range(MAX_PATTERN_LEN + 1, 63);
    endfunction

    function automatic void random_phase(int n);
        int first;
        first = gen_count;
        while (gen_count - first < n)
        begin
            case ($urandom_range(0, 9))
                0, 1: load_signature($urandom_range(0, NUM_SLOTS - 1), draw_length(),
                                     $urandom_range(0, 3) != 0);
                2: queue_load($urandom_range(0, NUM_SLOTS - 1),
                              $urandom_range(0, MAX_PATTERN_LEN - 1),
                              $urandom_range(0, 255), $urandom_range(0, 63));
                default: scan_buffer();
            endcase
        end
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (item_queue.size() != 0 || in_valid || pending_matches.size() != 0);
    endtask

    task automatic write_limit(int v);
        wait_drained();
        // loads and matchless bytes may still be in the pipeline
        repeat (8) @(negedge clk);
        @(posedge clk);
        cfg_data  <= POS_W'(v);
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (cfg_valid);
        limits_used++;
    endtask

    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
        begin
            limit_model = cfg_data;
            cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_item(cur_item);
                if (cur_item.kind == KIND_LOAD)
                    loads_done++;
                else
                    scans_done++;
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    cur_item = item_queue.pop_front();
                    kind           <= cur_item.kind;
                    slot           <= cur_item.slot;
                    pattern_length <= cur_item.plen;
                    byte_offset    <= cur_item.offs;
                    data_byte      <= cur_item.data;
                    buffer_start   <= cur_item.bstart;
                    in_valid       <= 1'b1;
                    in_gap = draw_wait(idle_in);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                matches_seen++;
                if (pending_matches.size() == 0)
                begin
                    $display("%0t: unexpected match start=%0d slot=%0d length=%0d last=%0b",
                             $time, match_start, match_slot, match_length, last);
                    errors++;
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (match_start !== want.start)
                    begin
                        $display("%0t: match_start expected %0d actual %0d",
                                 $time, want.start, match_start);
                        errors++;
                    end
                    if (match_slot !== want.slot)
                    begin
                        $display("%0t: match_slot expected %0d actual %0d",
                                 $time, want.slot, match_slot);
                        errors++;
                    end
                    if (match_length !== want.len)
                    begin
                        $display("%0t: match_length expected %0d actual %0d",
                                 $time, want.len, match_length);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                        errors++;
                    end
                end
                out_hold = draw_wait(idle_out);
            end
            else if (out_hold > 0)
            begin
                out_hold--;
            end
            out_stall <= (out_hold != 0);
        end
    end

    initial
    begin
        int lims[6];
        foreach (sig_len[s])
        begin
            sig_len[s]    = '0;
            gen_len[s]    = 0;
            gen_filled[s] = '0;
            for (int o = 0; o < MAX_PATTERN_LEN; o++)
            begin
                sig_mem[s][o] = '0;
                gen_sig[s][o] = '0;
            end
        end
        foreach (window[i])
            window[i] = '0;

        // directed: extremes, multi-slot hits, buffer boundaries
        push_load(0, 0, 8'h00, 1);
        push_load(7, 0, 8'hFF, 1);
        push_load(3, 0, 8'hA5, 2);
        push_load(3, 1, 8'h5A, 2);
        push_load(5, MAX_PATTERN_LEN - 1, 8'h11, 0);
        push_scan(8'h00, 1'b1);
        push_scan(8'hA5, 1'b0);
        push_scan(8'h5A, 1'b0);
        push_scan(8'hFF, 1'b0);
        push_scan(8'hA5, 1'b1);
        push_scan(8'h5A, 1'b0);
        push_scan(8'h5A, 1'b1);
        push_load(0, 0, 8'hFF, 1);
        push_scan(8'hFF, 1'b0);
        push_load(7, 0, 8'hFF, 0);
        push_scan(8'hFF, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // a zero limit ignores everything, a limit of one keeps only the first byte
        write_limit(0);
        push_scan(8'hFF, 1'b1);
        push_scan(8'hFF, 1'b0);
        write_limit(1);
        push_scan(8'hFF, 1'b1);
        push_scan(8'hFF, 1'b0);
        push_scan(8'hA5, 1'b1);
        push_scan(8'h5A, 1'b0);

        lims[0] = SCAN_LIMIT_RESET;
        lims[1] = 2;
        lims[2] = MAX_SCAN_POS;
        lims[3] = $urandom_range(3, 60);
        lims[4] = $urandom_range(1, MAX_SCAN_POS);
        lims[5] = 1;
        foreach (lims[i])
        begin
            write_limit(lims[i]);
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            if (i == 0)
            begin
                // nested runs of one byte: every slot hits on the same byte
                for (int s = 0; s < NUM_SLOTS; s++)
                    for (int o = 0; o <= s; o++)
                        push_load(s, o, 8'h41, (o == s) ? s + 1 : 0);
                for (int k = 0; k < 12; k++)
                    push_scan(8'h41, k == 0);
            end
            random_phase((i == 5) ? 15 : 30);
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (pending_matches.size() != 0)
        begin
            $display("%0t: %0d expected matches never arrived", $time, pending_matches.size());
            errors++;
        end
        $display("run covered %0d signature loads and %0d scanned bytes over %0d limit settings",
                 loads_done, scans_done, limits_used);
        $display("%0d matches checked, at most %0d on one byte, %0d errors",
                 matches_seen, most_hits, errors);
        if (errors == 0)
            $display("multi_signature_byte_scanner_core_test: PASS");
        else
            $display("multi_signature_byte_scanner_core_test: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/msbs_pkg.sv
rtl/msbs_front.sv
rtl/msbs_queue.sv
rtl/msbs_back.sv
rtl/multi_signature_byte_scanner_core.sv
bench/multi_signature_byte_scanner_core_test.sv
